// File: rtl/dpq_pkg.sv
`default_nettype none
package dpq_pkg;

   // operation codes on the request channel
   typedef enum logic [1:0] {
      OP_START      = 2'd0,
      OP_APPEND     = 2'd1,
      OP_QUERY_POP  = 2'd2,
      OP_QUERY_GRAD = 2'd3
   } op_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_ORDER = 2'd2
   } status_type;

   // one stored event: time, popularity Q16.16, gradient Q8.48
   typedef struct packed {
      logic [31:0] etime;
      logic [31:0] pop;
      logic [55:0] grad;
   } ev_type;

   localparam int          DIV_W      = 80;
   localparam int          DIVS_W     = 64;
   localparam logic [6:0]  DIV_STEPS  = 7'd80;
   localparam logic [31:0] ONE_Q31    = 32'h8000_0000;
   localparam logic [31:0] E1_Q31     = 32'd790015085;
   localparam logic [55:0] POP_ONE    = 56'd65536;
   localparam logic [55:0] MAX56      = {56{1'b1}};
   localparam logic [3:0]  TAYLOR_END = 4'd13;

   // ceil(2^36 / n): exact reciprocal for dividing a 32-bit value by n
   function automatic logic [35:0] recip(input logic [3:0] n);
      logic [35:0] m;
      m = 36'd0;
      case (n)
         4'd2:    m = 36'd34359738368;
         4'd3:    m = 36'd22906492246;
         4'd4:    m = 36'd17179869184;
         4'd5:    m = 36'd13743895348;
         4'd6:    m = 36'd11453246123;
         4'd7:    m = 36'd9817068106;
         4'd8:    m = 36'd8589934592;
         4'd9:    m = 36'd7635497416;
         4'd10:   m = 36'd6871947674;
         4'd11:   m = 36'd6247225158;
         4'd12:   m = 36'd5726623062;
         4'd13:   m = 36'd5286113596;
         default: m = 36'd0;
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

// File: rtl/decayed_popularity_query_unit.sv
`default_nettype none
// A start answers straight from the request; a full list and an append to an empty list answer
// after the item table read, an out-of-order append after the last event read, and queries scan
// their events one per cycle. Decaying work squares tau, runs the restoring dividers and the exp
// series, multiplies by exp(-1) once per whole tau period (at most 31) and multiplies once (twice
// on append). One item at a time; a new request is taken while the last response still waits.
// Reset clears control, then sweeps the item table with req_stall high.
module decayed_popularity_query_unit #(
   parameter int unsigned ITEMS           = 256,
   parameter int unsigned EVENTS_PER_ITEM = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [7:0]  req_item,
   input  wire logic [31:0] req_event_time,
   input  wire logic [31:0] req_decay_constant,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [55:0]      rsp_value,
   output logic [1:0]       rsp_status
);

   localparam int IW  = $clog2(ITEMS);
   localparam int CW  = $clog2(EVENTS_PER_ITEM + 1);
   localparam int EN  = ITEMS * EVENTS_PER_ITEM;
   localparam int AW  = $clog2(EN);
   localparam int IMW = 32 + CW;
   localparam logic [CW-1:0] CNT_FULL  = CW'(EVENTS_PER_ITEM);
   localparam logic [IW-1:0] ITEM_LAST = IW'(ITEMS - 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ITEM, S_SEARCH, S_LAST, S_SQ, S_DIVGO, S_DIV,
      S_EXP, S_MUL_HI, S_MUL_LO, S_MUL_SUM, S_DONE
   } state_type;

   // memories
   logic [IMW-1:0]   item_mem [ITEMS];
   dpq_pkg::ev_type  ev_mem [EN];
   logic [IMW-1:0]   item_rd_ff;
   dpq_pkg::ev_type  ev_rd_ff;
   logic             item_we, ev_we;
   logic [IW-1:0]    item_wa, item_ra;
   logic [IMW-1:0]   item_wd;
   logic [AW-1:0]    ev_wa, ev_ra;
   dpq_pkg::ev_type  ev_wd;

   // control and working registers
   state_type           state_ff, state_in;
   dpq_pkg::op_type     op_ff, op_in;
   dpq_pkg::status_type status_ff, status_in;
   logic [31:0]         time_ff, time_in;
   logic [IW-1:0]       item_ff, item_in;
   logic [AW-1:0]       base_ff, base_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [CW-1:0]       j_ff, j_in;
   logic [31:0]         tau_ff, tau_in;
   dpq_pkg::ev_type     hit_ff, hit_in;
   logic                hit_vld_ff, hit_vld_in;
   logic [31:0]         dt_ff, dt_in;
   logic [63:0]         t2_ff, t2_in;
   logic [31:0]         e_ff, e_in;
   logic [55:0]         gterm_ff, gterm_in;
   logic                mul_grad_ff, mul_grad_in;
   logic [63:0]         prod_hi_ff, prod_hi_in;
   logic [55:0]         prod_lo_ff, prod_lo_in;
   logic [31:0]         p_new_ff, p_new_in;
   logic [55:0]         value_ff, value_in;
   logic [IW-1:0]       clr_ff, clr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [55:0]         rsp_value_ff, rsp_value_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;

   // arithmetic units
   logic                       div_start, exp_start;
   logic                       diva_done, divb_done, exp_done;
   logic [dpq_pkg::DIV_W-1:0]  quo_a, quo_b;
   logic [31:0]                exp_factor;

   logic [IW-1:0]  req_idx;
   logic           in_range;
   logic [31:0]    item_tau;
   logic [CW-1:0]  item_cnt;
   logic [56:0]    grad_sum;
   logic [55:0]    grad_sat;
   logic [55:0]    pop_one;
   logic [55:0]    mul_v;
   logic [56:0]    mul_lo_sum;
   logic [57:0]    mul_res;
   logic [31:0]    p_sat;
   logic [CW-1:0]  j_next;

   assign req_idx  = IW'(req_item);
   assign in_range = {24'd0, req_item} < 32'(ITEMS);
   assign item_tau = item_rd_ff[IMW-1:CW];
   assign item_cnt = item_rd_ff[CW-1:0];
   assign j_next   = j_ff + CW'(1);

   // operand and result of the Q31 multiply
   assign grad_sum   = {1'b0, hit_ff.grad} + {1'b0, gterm_ff};
   assign grad_sat   = grad_sum[56] ? dpq_pkg::MAX56 : grad_sum[55:0];
   assign pop_one    = {24'd0, hit_ff.pop} + dpq_pkg::POP_ONE;
   assign mul_v      = mul_grad_ff ? grad_sat : pop_one;
   assign mul_lo_sum = {26'd0, prod_hi_ff[6:0], 24'd0} + {1'b0, prod_lo_ff};
   assign mul_res    = {1'b0, prod_hi_ff[63:7]} + {32'd0, mul_lo_sum[56:31]};
   assign p_sat      = (|mul_res[57:32]) ? 32'hFFFF_FFFF : mul_res[31:0];

   dpq_div u_div_exp (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({17'd0, dt_ff, 31'd0}),
      .divisor  ({32'd0, tau_ff}),
      .done     (diva_done),
      .quotient (quo_a)
   );

   dpq_div u_div_grad (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({dt_ff, 48'd0}),
      .divisor  (t2_ff),
      .done     (divb_done),
      .quotient (quo_b)
   );

   dpq_exp u_exp (
      .clock     (clock),
      .reset     (reset),
      .start     (exp_start),
      .frac      (quo_a[30:0]),
      .whole     (quo_a[35:31]),
      .whole_big (|quo_a[79:36]),
      .done      (exp_done),
      .factor    (exp_factor)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      status_in     = status_ff;
      time_in       = time_ff;
      item_in       = item_ff;
      base_in       = base_ff;
      cnt_in        = cnt_ff;
      j_in          = j_ff;
      tau_in        = tau_ff;
      hit_in        = hit_ff;
      hit_vld_in    = hit_vld_ff;
      dt_in         = dt_ff;
      t2_in         = t2_ff;
      e_in          = e_ff;
      gterm_in      = gterm_ff;
      mul_grad_in   = mul_grad_ff;
      prod_hi_in    = prod_hi_ff;
      prod_lo_in    = prod_lo_ff;
      p_new_in      = p_new_ff;
      value_in      = value_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      item_we       = 1'b0;
      item_wa       = req_idx;
      item_wd       = '0;
      item_ra       = req_idx;
      ev_we         = 1'b0;
      ev_wa         = base_ff + AW'(cnt_ff);
      ev_wd         = '{etime: time_ff, pop: p_new_ff, grad: mul_res[55:0]};
      ev_ra         = base_ff + AW'(j_next);
      div_start     = 1'b0;
      exp_start     = 1'b0;

      // drop the response once it is transferred
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      unique case (state_ff)
         // sweep the item table to zero counts after reset
         S_CLEAR: begin
            item_we = 1'b1;
            item_wa = clr_ff;
            item_wd = '0;
            clr_in  = clr_ff + IW'(1);
            if (clr_ff == ITEM_LAST) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in      = dpq_pkg::op_type'(req_operation);
               time_in    = req_event_time;
               item_in    = req_idx;
               base_in    = AW'(req_idx) * AW'(EVENTS_PER_ITEM);
               value_in   = 56'd0;
               status_in  = dpq_pkg::ST_OK;
               hit_vld_in = 1'b0;
               j_in       = '0;
               if (!in_range) begin
                  state_in = S_DONE;
               end else if (dpq_pkg::op_type'(req_operation) == dpq_pkg::OP_START) begin
                  item_we  = 1'b1;
                  item_wd  = {req_decay_constant, CW'(0)};
                  state_in = S_DONE;
               end else begin
                  state_in = S_ITEM;
               end
            end
         end
         S_ITEM: begin
            tau_in = (item_tau == 32'd0) ? 32'd1 : item_tau;
            cnt_in = item_cnt;
            if (op_ff == dpq_pkg::OP_APPEND) begin
               if (item_cnt == CNT_FULL) begin
                  status_in = dpq_pkg::ST_FULL;
                  state_in  = S_DONE;
               end else if (item_cnt == '0) begin
                  // first event carries zero popularity and gradient
                  ev_we    = 1'b1;
                  ev_wa    = base_ff;
                  ev_wd    = '{etime: time_ff, pop: 32'd0, grad: 56'd0};
                  item_we  = 1'b1;
                  item_wa  = item_ff;
                  item_wd  = {item_tau, CW'(1)};
                  state_in = S_DONE;
               end else begin
                  ev_ra    = base_ff + AW'(item_cnt - CW'(1));
                  state_in = S_LAST;
               end
            end else begin
               if (item_cnt == '0) begin
                  state_in = S_DONE;
               end else begin
                  ev_ra    = base_ff;
                  state_in = S_SEARCH;
               end
            end
         end
         // scan forward, one event per cycle, keeping the last match
         S_SEARCH: begin
            if ((op_ff == dpq_pkg::OP_QUERY_POP) ? (ev_rd_ff.etime <= time_ff)
                                                 : (ev_rd_ff.etime < time_ff)) begin
               hit_in     = ev_rd_ff;
               hit_vld_in = 1'b1;
               j_in       = j_next;
               if (j_next == cnt_ff) begin
                  if (op_ff == dpq_pkg::OP_QUERY_POP && ev_rd_ff.etime == time_ff) begin
                     value_in = {24'd0, ev_rd_ff.pop} + dpq_pkg::POP_ONE;
                     state_in = S_DONE;
                  end else begin
                     dt_in    = time_ff - ev_rd_ff.etime;
                     state_in = S_SQ;
                  end
               end
            end else begin
               if (!hit_vld_ff) begin
                  state_in = S_DONE;
               end else if (op_ff == dpq_pkg::OP_QUERY_POP && hit_ff.etime == time_ff) begin
                  value_in = pop_one;
                  state_in = S_DONE;
               end else begin
                  dt_in    = time_ff - hit_ff.etime;
                  state_in = S_SQ;
               end
            end
         end
         S_LAST: begin
            if (time_ff < ev_rd_ff.etime) begin
               status_in = dpq_pkg::ST_ORDER;
               state_in  = S_DONE;
            end else begin
               hit_in   = ev_rd_ff;
               dt_in    = time_ff - ev_rd_ff.etime;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            t2_in    = {32'd0, tau_ff} * {32'd0, tau_ff};
            state_in = S_DIVGO;
         end
         S_DIVGO: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (diva_done && divb_done) begin
               gterm_in  = (|quo_b[79:56]) ? dpq_pkg::MAX56 : quo_b[55:0];
               exp_start = 1'b1;
               state_in  = S_EXP;
            end
         end
         S_EXP: begin
            if (exp_done) begin
               e_in        = exp_factor;
               mul_grad_in = (op_ff == dpq_pkg::OP_QUERY_GRAD);
               state_in    = S_MUL_HI;
            end
         end
         S_MUL_HI: begin
            prod_hi_in = {32'd0, mul_v[55:24]} * {32'd0, e_ff};
            state_in   = S_MUL_LO;
         end
         S_MUL_LO: begin
            prod_lo_in = {32'd0, mul_v[23:0]} * {24'd0, e_ff};
            state_in   = S_MUL_SUM;
         end
         S_MUL_SUM: begin
            if (!mul_grad_ff) begin
               if (op_ff == dpq_pkg::OP_APPEND) begin
                  p_new_in    = p_sat;
                  mul_grad_in = 1'b1;
                  state_in    = S_MUL_HI;
               end else begin
                  value_in = mul_res[55:0];
                  state_in = S_DONE;
               end
            end else begin
               if (op_ff == dpq_pkg::OP_APPEND) begin
                  // commit the new event and bump the count
                  ev_we   = 1'b1;
                  item_we = 1'b1;
                  item_wa = item_ff;
                  item_wd = {tau_ff, cnt_ff + CW'(1)};
               end else begin
                  value_in = mul_res[55:0];
               end
               state_in = S_DONE;
            end
         end
         // hand the result to the output register when it is free
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = value_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      status_ff     <= status_in;
      time_ff       <= time_in;
      item_ff       <= item_in;
      base_ff       <= base_in;
      cnt_ff        <= cnt_in;
      j_ff          <= j_in;
      tau_ff        <= tau_in;
      hit_ff        <= hit_in;
      hit_vld_ff    <= hit_vld_in;
      dt_ff         <= dt_in;
      t2_ff         <= t2_in;
      e_ff          <= e_in;
      gterm_ff      <= gterm_in;
      mul_grad_ff   <= mul_grad_in;
      prod_hi_ff    <= prod_hi_in;
      prod_lo_ff    <= prod_lo_in;
      p_new_ff      <= p_new_in;
      value_ff      <= value_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item table: tau and event count
   always_ff @(posedge clock) begin
      if (item_we) item_mem[item_wa] <= item_wd;
      item_rd_ff <= item_mem[item_ra];
   end

   // event history
   always_ff @(posedge clock) begin
      if (ev_we) ev_mem[ev_wa] <= ev_wd;
      ev_rd_ff <= ev_mem[ev_ra];
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule
`default_nettype wire

// File: rtl/dpq_div.sv
`default_nettype none
module dpq_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [dpq_pkg::DIV_W-1:0]  dividend,
   input  wire logic [dpq_pkg::DIVS_W-1:0] divisor,
   output logic                            done,
   output logic [dpq_pkg::DIV_W-1:0]       quotient
);

   logic [dpq_pkg::DIV_W-1:0]  quo_ff, quo_in;
   logic [dpq_pkg::DIVS_W-1:0] rem_ff, rem_in;
   logic [dpq_pkg::DIVS_W-1:0] den_ff, den_in;
   logic [6:0]                 cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [dpq_pkg::DIVS_W:0]   rem_sh;
   logic [dpq_pkg::DIVS_W:0]   rem_sub;
   logic                       fits;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign rem_sh  = {rem_ff, quo_ff[dpq_pkg::DIV_W-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};
   assign fits    = rem_sh >= {1'b0, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = dpq_pkg::DIV_STEPS;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[dpq_pkg::DIV_W-2:0], fits};
         rem_in = fits ? rem_sub[dpq_pkg::DIVS_W-1:0] : rem_sh[dpq_pkg::DIVS_W-1:0];
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// File: rtl/dpq_exp.sv
`default_nettype none
module dpq_exp (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [30:0] frac,
   input  wire logic [4:0]  whole,
   input  wire logic        whole_big,
   output logic             done,
   output logic [31:0]      factor
);

   typedef enum logic [2:0] {
      E_IDLE, E_MUL, E_DIV, E_FIN, E_POW
   } state_type;

   state_type   state_ff, state_in;
   logic        done_ff, done_in;
   logic [30:0] x_ff, x_in;
   logic [4:0]  k_ff, k_in;
   logic [3:0]  n_ff, n_in;
   logic [31:0] term_ff, term_in;
   logic [31:0] y_ff, y_in;
   logic [34:0] even_ff, even_in;
   logic [34:0] odd_ff, odd_in;
   logic [31:0] e_ff, e_in;
   logic [63:0] term_prod;
   logic [67:0] recip_prod;
   logic [31:0] term_next;
   logic [34:0] diff;
   logic [63:0] pow_prod;

   assign term_prod  = {32'd0, term_ff} * {33'd0, x_ff};
   assign recip_prod = {36'd0, y_ff} * {32'd0, dpq_pkg::recip(n_ff)};
   assign term_next  = (n_ff == 4'd1) ? y_ff : recip_prod[67:36];
   assign diff       = (even_ff > odd_ff) ? even_ff - odd_ff : 35'd0;
   assign pow_prod   = {32'd0, e_ff} * {32'd0, dpq_pkg::E1_Q31};

   always_comb begin
      state_in = state_ff;
      done_in  = done_ff;
      x_in     = x_ff;
      k_in     = k_ff;
      n_in     = n_ff;
      term_in  = term_ff;
      y_in     = y_ff;
      even_in  = even_ff;
      odd_in   = odd_ff;
      e_in     = e_ff;
      unique case (state_ff)
         E_IDLE: begin
            if (start) begin
               done_in = 1'b0;
               x_in    = frac;
               k_in    = whole;
               n_in    = 4'd1;
               term_in = dpq_pkg::ONE_Q31;
               even_in = {3'd0, dpq_pkg::ONE_Q31};
               odd_in  = 35'd0;
               // too many whole periods: the factor underflows to zero
               if (whole_big) begin
                  e_in    = 32'd0;
                  done_in = 1'b1;
               end else begin
                  state_in = E_MUL;
               end
            end
         end
         E_MUL: begin
            y_in     = term_prod[62:31];
            state_in = E_DIV;
         end
         // divide by the term index and add into the even or odd sum
         E_DIV: begin
            term_in = term_next;
            if (n_ff[0]) odd_in = odd_ff + {3'd0, term_next};
            else         even_in = even_ff + {3'd0, term_next};
            if (n_ff == dpq_pkg::TAYLOR_END) begin
               state_in = E_FIN;
            end else begin
               n_in     = n_ff + 4'd1;
               state_in = E_MUL;
            end
         end
         E_FIN: begin
            e_in = (diff > {3'd0, dpq_pkg::ONE_Q31}) ? dpq_pkg::ONE_Q31 : diff[31:0];
            if (k_ff == 5'd0) begin
               done_in  = 1'b1;
               state_in = E_IDLE;
            end else begin
               state_in = E_POW;
            end
         end
         // multiply by exp(-1) once per whole period
         E_POW: begin
            e_in = pow_prod[62:31];
            k_in = k_ff - 5'd1;
            if (k_ff == 5'd1) begin
               done_in  = 1'b1;
               state_in = E_IDLE;
            end
         end
         default: state_in = E_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      k_ff    <= k_in;
      n_ff    <= n_in;
      term_ff <= term_in;
      y_ff    <= y_in;
      even_ff <= even_in;
      odd_ff  <= odd_in;
      e_ff    <= e_in;
      if (reset) begin
         state_ff <= E_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign done   = done_ff;
   assign factor = e_ff;

endmodule
`default_nettype wire

// File: tb/sv/dpq_checker.sv
`default_nettype none
module dpq_checker #(
   parameter int unsigned ITEMS           = 256,
   parameter int unsigned EVENTS_PER_ITEM = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [7:0]  req_item,
   input  wire logic [31:0] req_event_time,
   input  wire logic [31:0] req_decay_constant,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [55:0] rsp_value,
   input  wire logic [1:0]  rsp_status,
   output int               fail_count,
   output int               awaited_count,
   output int               checked_count
);

   localparam logic [63:0] Q31_ONE = 64'h8000_0000;
   localparam logic [63:0] SAT56   = 64'h00FF_FFFF_FFFF_FFFF;
   localparam logic [63:0] UNIT    = 64'd65536;

   typedef struct {
      logic [55:0]         value;
      dpq_pkg::status_type status;
   } answer_type;

   // shadow copy of the item table and event histories
   logic [31:0] tau_of      [ITEMS];
   int          events_of   [ITEMS];
   logic [31:0] ev_time     [ITEMS][EVENTS_PER_ITEM];
   logic [31:0] ev_pop      [ITEMS][EVENTS_PER_ITEM];
   logic [63:0] ev_grad     [ITEMS][EVENTS_PER_ITEM];
   answer_type  awaited_answers[$];

   // floor(v * e / 2^31), exact for v < 2^56
   function automatic logic [63:0] q31_scale(input logic [63:0] v, input logic [63:0] e);
      logic [63:0] hi_part, lo_part;
      hi_part = (v >> 24) * e;
      lo_part = (v & 64'hFF_FFFF) * e;
      return (hi_part >> 7) + ((((hi_part & 64'h7F) << 24) + lo_part) >> 31);
   endfunction

   // Taylor series of exp(-x), x in Q1.31 within [0, 1]
   function automatic logic [63:0] exp_unit(input logic [63:0] x);
      logic [63:0] even_sum, odd_sum, term, diff;
      even_sum = 0;
      odd_sum  = 0;
      term     = Q31_ONE;
      for (int n = 0; n <= 13; n++) begin
         if (n % 2 == 0) even_sum += term;
         else odd_sum += term;
         term = ((term * x) >> 31) / (n + 1);
      end
      diff = (even_sum > odd_sum) ? even_sum - odd_sum : 64'd0;
      return (diff > Q31_ONE) ? Q31_ONE : diff;
   endfunction

   function automatic logic [63:0] decay_weight(input logic [31:0] dt, input logic [31:0] tau);
      logic [63:0] t, whole, frac, e, e1;
      t     = (tau == 0) ? 64'd1 : {32'd0, tau};
      whole = dt / t;
      frac  = dt % t;
      if (whole >= 32) return 64'd0;
      e  = exp_unit((frac << 31) / t);
      e1 = exp_unit(Q31_ONE);
      for (int k = 0; k < whole; k++) e = (e * e1) >> 31;
      return e;
   endfunction

   // floor(dt * 2^48 / tau^2), saturating
   function automatic logic [63:0] grad_increment(input logic [31:0] dt,
                                                  input logic [31:0] tau);
      logic [63:0] t, t2, acc, rem;
      logic        top;
      t   = (tau == 0) ? 64'd1 : {32'd0, tau};
      t2  = t * t;
      acc = dt / t2;
      rem = dt % t2;
      if (acc >= 256) return SAT56;
      for (int k = 0; k < 48; k++) begin
         top = rem[63];
         rem = rem << 1;
         acc = acc << 1;
         if (top || rem >= t2) begin
            rem = rem - t2;
            acc = acc | 64'd1;
         end
      end
      return acc;
   endfunction

   function automatic logic [63:0] grad_decayed(input logic [63:0] g, input logic [31:0] dt,
                                                input logic [31:0] tau);
      logic [63:0] s;
      s = g + grad_increment(dt, tau);
      if (s > SAT56) s = SAT56;
      return q31_scale(s, decay_weight(dt, tau));
   endfunction

   // apply one request to the shadow table and return its answer
   function automatic answer_type apply_request(input dpq_pkg::op_type op, input int it,
                                                input logic [31:0] t,
                                                input logic [31:0] tau_in);
      answer_type  ans;
      int          n, j;
      logic [63:0] p, g;
      logic [31:0] dt, last_t;
      ans.value  = '0;
      ans.status = dpq_pkg::ST_OK;
      n = events_of[it];
      case (op)
         dpq_pkg::OP_START: begin
            tau_of[it]    = tau_in;
            events_of[it] = 0;
         end
         dpq_pkg::OP_APPEND: begin
            if (n >= EVENTS_PER_ITEM) begin
               ans.status = dpq_pkg::ST_FULL;
            end else if (n > 0 && t < ev_time[it][n-1]) begin
               ans.status = dpq_pkg::ST_ORDER;
            end else begin
               p = 0;
               g = 0;
               if (n > 0) begin
                  last_t = ev_time[it][n-1];
                  dt = t - last_t;
                  p = q31_scale({32'd0, ev_pop[it][n-1]} + UNIT, decay_weight(dt, tau_of[it]));
                  if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
                  g = grad_decayed(ev_grad[it][n-1], dt, tau_of[it]);
               end
               ev_time[it][n] = t;
               ev_pop[it][n]  = p[31:0];
               ev_grad[it][n] = g;
               events_of[it]  = n + 1;
            end
         end
         dpq_pkg::OP_QUERY_POP: begin
            j = 0;
            while (j < n && ev_time[it][j] <= t) j++;
            if (j > 0) begin
               p = {32'd0, ev_pop[it][j-1]} + UNIT;
               if (ev_time[it][j-1] == t) ans.value = p[55:0];
               else ans.value = 56'(q31_scale(p, decay_weight(t - ev_time[it][j-1],
                                                             tau_of[it])));
            end
         end
         default: begin
            j = 0;
            while (j < n && ev_time[it][j] < t) j++;
            if (j > 0)
               ans.value = 56'(grad_decayed(ev_grad[it][j-1], t - ev_time[it][j-1],
                                            tau_of[it]));
         end
      endcase
      return ans;
   endfunction

   // predict on each request transfer, compare on each response transfer
   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         fail_count    <= 0;
         checked_count <= 0;
         awaited_count <= 0;
         for (int i = 0; i < ITEMS; i++) events_of[i] = 0;
      end else begin
         if (req_valid && !req_stall)
            awaited_answers.push_back(apply_request(dpq_pkg::op_type'(req_operation),
                                                    req_item, req_event_time,
                                                    req_decay_constant));
         if (rsp_valid && !rsp_stall) begin
            checked_count <= checked_count + 1;
            if (awaited_answers.size() == 0) begin
               $display("%0t: response with nothing awaited: value %h status %0d",
                        $time, rsp_value, rsp_status);
               fail_count <= fail_count + 1;
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_value !== want.value || rsp_status !== want.status) begin
                  $display("%0t: value expected %h actual %h, status expected %0d actual %0d",
                           $time, want.value, rsp_value, want.status, rsp_status);
                  fail_count <= fail_count + 1;
               end
            end
         end
         awaited_count <= awaited_answers.size();
      end
   end

endmodule
`default_nettype wire

// File: tb/sv/decayed_popularity_query_unit_tb.sv
`default_nettype none
module decayed_popularity_query_unit_tb;

   localparam int RANDOM_REQUESTS = 1500;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = dpq_pkg::OP_START;
   logic [7:0]  req_item = '0;
   logic [31:0] req_event_time = '0;
   logic [31:0] req_decay_constant = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [55:0] rsp_value;
   logic [1:0]  rsp_status;
   int          fail_count, awaited_count, checked_count;

   // stimulus-side view: which items have a tau, their last accepted time and count
   bit          started   [256];
   logic [31:0] last_time [256];
   logic [31:0] tau_used  [256];
   int          stored    [256];
   int          op_sent   [4];
   int          burst_left = 0;
   logic [7:0]  hot_items [6];

   decayed_popularity_query_unit i_dut (.*);

   dpq_checker i_checker (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #40_000_000;
      $display("timeout with %0d responses outstanding", awaited_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // receiver stall pattern: rotates through no stall, random stall and mostly stalled modes
   always @(negedge clock) begin
      int mode_cycle;
      mode_cycle = int'(($time / 12) % 900);
      if (mode_cycle < 300) rsp_stall <= 1'b0;
      else if (mode_cycle < 600) rsp_stall <= ($urandom_range(0, 1) == 1);
      else rsp_stall <= ($urandom_range(0, 9) < 8);
   end

   // present one request and hold it until transfer, then idle between bursts
   task automatic send_request(input dpq_pkg::op_type op, input logic [7:0] it,
                               input logic [31:0] t, input logic [31:0] tau);
      req_valid          = 1'b1;
      req_operation      = op;
      req_item           = it;
      req_event_time     = t;
      req_decay_constant = tau;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      req_valid = 1'b0;
      op_sent[op]++;
      // track what the block will hold
      if (op == dpq_pkg::OP_START) begin
         started[it]  = 1'b1;
         stored[it]   = 0;
         tau_used[it] = tau;
      end else if (op == dpq_pkg::OP_APPEND && stored[it] < 64 &&
                   (stored[it] == 0 || t >= last_time[it])) begin
         stored[it]++;
         last_time[it] = t;
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         repeat ($urandom_range(0, 15)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 25);
      end
   endtask

   function automatic logic [31:0] near_time(input logic [31:0] base, input logic [31:0] tau);
      longint span, sum;
      case ($urandom_range(0, 4))
         0: span = 0;
         1: span = $urandom_range(0, 3);
         2: span = (tau < 1000) ? $urandom_range(0, tau + 1) : $urandom_range(0, 1000);
         3: span = (tau < 100_000_000) ? $urandom_range(0, tau * 40 + 1) : $urandom();
         default: return $urandom();
      endcase
      sum = longint'(base) + span;
      return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   function automatic logic [31:0] pick_tau();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return $urandom_range(1, 4);
         2: return $urandom_range(1, 200);
         3: return $urandom_range(1, 1_000_000);
         4: return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   initial begin
      logic [7:0]  it;
      logic [31:0] t;
      int          roll;
      for (int i = 0; i < 256; i++) begin
         started[i] = 1'b0;
         stored[i]  = 0;
         last_time[i] = '0;
         tau_used[i]  = '0;
      end
      for (int i = 0; i < 4; i++) op_sent[i] = 0;
      for (int i = 0; i < 6; i++) hot_items[i] = $urandom_range(0, 255);
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: zero tau, exact and decayed queries, order error, extreme values
      send_request(dpq_pkg::OP_QUERY_POP, 8'd255, 32'hFFFF_FFFF, '0);
      send_request(dpq_pkg::OP_START, 8'd0, 32'd5, 32'd0);
      send_request(dpq_pkg::OP_QUERY_GRAD, 8'd0, 32'd10, '0);
      send_request(dpq_pkg::OP_APPEND, 8'd0, 32'd0, '0);
      send_request(dpq_pkg::OP_APPEND, 8'd0, 32'd3, '0);
      send_request(dpq_pkg::OP_APPEND, 8'd0, 32'd2, '0);
      send_request(dpq_pkg::OP_APPEND, 8'd0, 32'd3, '0);
      send_request(dpq_pkg::OP_QUERY_POP, 8'd0, 32'd3, '0);
      send_request(dpq_pkg::OP_QUERY_POP, 8'd0, 32'd4, '0);
      send_request(dpq_pkg::OP_QUERY_POP, 8'd0, 32'd100, '0);
      send_request(dpq_pkg::OP_QUERY_GRAD, 8'd0, 32'd3, '0);
      send_request(dpq_pkg::OP_QUERY_GRAD, 8'd0, 32'd0, '0);
      send_request(dpq_pkg::OP_QUERY_GRAD, 8'd0, 32'hFFFF_FFFF, '0);
      send_request(dpq_pkg::OP_START, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(dpq_pkg::OP_APPEND, 8'd255, 32'd0, '0);
      send_request(dpq_pkg::OP_APPEND, 8'd255, 32'hFFFF_FFFF, '0);
      send_request(dpq_pkg::OP_QUERY_POP, 8'd255, 32'h8000_0000, '0);
      send_request(dpq_pkg::OP_QUERY_GRAD, 8'd255, 32'hFFFF_FFFF, '0);
      send_request(dpq_pkg::OP_START, 8'd0, 32'd7, 32'd40);
      send_request(dpq_pkg::OP_QUERY_POP, 8'd0, 32'd3, '0);

      // random: mostly in-order histories on a few hot items so lists fill up
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         it = ($urandom_range(0, 9) < 8) ? hot_items[$urandom_range(0, 5)]
                                         : 8'($urandom_range(0, 255));
         roll = $urandom_range(0, 99);
         if (!started[it] || roll < 4) begin
            send_request(dpq_pkg::OP_START, it, $urandom(), pick_tau());
         end else if (roll < 60) begin
            t = ($urandom_range(0, 9) == 0) ? $urandom() : near_time(last_time[it], tau_used[it]);
            send_request(dpq_pkg::OP_APPEND, it, t, $urandom());
         end else begin
            t = near_time(($urandom_range(0, 1) == 0) ? 32'd0 : last_time[it] - 32'd50,
                          tau_used[it]);
            if ($urandom_range(0, 4) == 0) t = last_time[it];
            send_request(($urandom_range(0, 1) == 0) ? dpq_pkg::OP_QUERY_POP
                                                     : dpq_pkg::OP_QUERY_GRAD,
                         it, t, $urandom());
         end
      end

      // drain, then allow the block's worst latency
      while (awaited_count != 0) @(negedge clock);
      repeat (400) @(negedge clock);
      $display("covered %0d starts, %0d appends, %0d popularity and %0d gradient queries",
               op_sent[dpq_pkg::OP_START], op_sent[dpq_pkg::OP_APPEND],
               op_sent[dpq_pkg::OP_QUERY_POP], op_sent[dpq_pkg::OP_QUERY_GRAD]);
      $display("%0d responses compared, %0d mismatches", checked_count, fail_count);
      if (fail_count == 0 && awaited_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire
